// File: src/i2c_register_master_assert.svh
// Assertion macros shared by the register master RTL.
`ifndef I2C_REGISTER_MASTER_ASSERT_SVH
`define I2C_REGISTER_MASTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define I2CRM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define I2CRM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/i2crm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package i2crm_pkg;

    localparam int MAX_BURST_DEFAULT = 32;

    localparam logic [6:0]  ADDR_RESET    = 7'h0E;
    localparam logic [15:0] PHASE_RESET   = 16'd2;
    localparam logic [15:0] STRETCH_RESET = 16'd2000;
    localparam logic [3:0]  RECOVER_COUNT = 4'd9;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEVICE_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_PHASE_TICKS    = 2'd1;
    localparam logic [1:0] CFG_STRETCH_LIMIT  = 2'd2;

    // Operations
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_PROBE   = 3'd3;
    localparam logic [2:0] OP_RECOVER = 3'd4;

    // Completion status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NACK    = 2'd1;
    localparam logic [1:0] ST_TIMEOUT = 2'd2;

    // Sequence steps
    localparam logic [3:0] EL_IDLE    = 4'd0;
    localparam logic [3:0] EL_START   = 4'd1;
    localparam logic [3:0] EL_ADDR_W  = 4'd2;
    localparam logic [3:0] EL_REG     = 4'd3;
    localparam logic [3:0] EL_VAL     = 4'd4;
    localparam logic [3:0] EL_RESTART = 4'd5;
    localparam logic [3:0] EL_ADDR_R  = 4'd6;
    localparam logic [3:0] EL_READ    = 4'd7;
    localparam logic [3:0] EL_STOP    = 4'd8;
    localparam logic [3:0] EL_CLOCKS  = 4'd9;

    // Bus phases
    localparam logic [3:0] PH_NONE       = 4'd0;
    localparam logic [3:0] PH_START_RISE = 4'd1;
    localparam logic [3:0] PH_START_WAIT = 4'd2;
    localparam logic [3:0] PH_START_SDA  = 4'd3;
    localparam logic [3:0] PH_START_SCL  = 4'd4;
    localparam logic [3:0] PH_BIT_RISE   = 4'd5;
    localparam logic [3:0] PH_BIT_WAIT   = 4'd6;
    localparam logic [3:0] PH_BIT_HIGH   = 4'd7;
    localparam logic [3:0] PH_BIT_LOW    = 4'd8;
    localparam logic [3:0] PH_STOP_SDA   = 4'd9;
    localparam logic [3:0] PH_STOP_RISE  = 4'd10;
    localparam logic [3:0] PH_STOP_WAIT  = 4'd11;
    localparam logic [3:0] PH_STOP_END   = 4'd12;
    localparam logic [3:0] PH_CLK_RISE   = 4'd13;
    localparam logic [3:0] PH_CLK_HIGH   = 4'd14;
    localparam logic [3:0] PH_CLK_LOW    = 4'd15;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] reg_addr;
        logic [7:0] write_value;
        logic [5:0] read_count;
        logic       sda_sample;
        logic       scl_sample;
    } in_item_t;

    typedef struct packed {
        logic       sda_pull_low;
        logic       scl_pull_low;
        logic       busy_res;
        logic       byte_valid;
        logic [7:0] byte_value;
        logic       byte_last;
        logic       done_res;
        logic [1:0] status;
        logic       command_ignored;
    } out_item_t;

endpackage

`default_nettype wire

// File: src/i2c_register_master.sv
`timescale 1ns / 1ps
`default_nettype none
// Open-drain I2C register master, stepped one bus tick per input transfer.
// Input channel (s_valid/s_ready/s_data): each transfer carries a command code,
// its operands and the SDA/SCL levels sampled for this tick. Commands are taken
// only while idle; one arriving while busy is dropped and flagged.
// Result channel (m_valid/m_ready/m_data): exactly one result per input transfer,
// giving the pull-low levels for both lines after this tick, busy, a read byte
// when one completes, and done with a status when a command ends.
// Configuration: cfg_wr_en/cfg_wr_index/cfg_wr_data write device address, phase
// length or stretch limit, one per write; write them only while the block is idle.
// The result is registered and appears in the cycle after its input transfer.
// Throughput is one transfer per cycle while results are taken: the whole tick
// update is one pass of logic from the state registers into the result register.
// Reset (aresetn low, synchronous) returns to idle with both lines released and
// the registers at their defaults. When the receiver stalls, the result is held
// and s_ready drops until it is taken; a result being taken frees the register in
// the same cycle.
module i2c_register_master
    import i2crm_pkg::*;
#(
    parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

`include "i2c_register_master_assert.svh"

    localparam logic [5:0] BURST_MAX = 6'(MAX_BURST);

    logic [6:0]  dev_addr_reg;
    logic [15:0] phase_ticks_reg;
    logic [15:0] stretch_limit_reg;

    logic [3:0]  step_reg, step_next;
    logic [3:0]  phase_reg, phase_next;
    logic [15:0] phase_cnt_reg, phase_cnt_next;
    logic [15:0] stretch_cnt_reg, stretch_cnt_next;
    logic [3:0]  bit_cnt_reg, bit_cnt_next;
    logic [5:0]  bytes_done_reg, bytes_done_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  command_reg, command_next;
    logic [7:0]  held_register_reg, held_register_next;
    logic [7:0]  held_value_reg, held_value_next;
    logic [5:0]  held_count_reg, held_count_next;
    logic        sda_reg, sda_next;
    logic        scl_reg, scl_next;
    logic [3:0]  recover_reg, recover_next;
    logic        nack_reg, nack_next;
    logic [1:0]  pending_reg, pending_next;

    logic        m_valid_reg;
    out_item_t   m_data_reg;
    out_item_t   result;

    logic        accept;
    logic [15:0] phase_limit;
    logic [15:0] phase_inc;
    logic [15:0] stretch_inc;
    logic        delay_over;
    logic        stretch_over;
    logic [3:0]  recover_inc;

    // SDA level for the next bit: data bits drive the inverse of the bit
    // (low for zero), the ACK slot of a read releases SDA only on the last byte.
    function automatic logic bit_sda(input logic [3:0] step, input logic [3:0] bit_cnt,
                                     input logic [7:0] shifted, input logic [5:0] done,
                                     input logic [5:0] count);
        logic [7:0] aligned;
        logic       drive;
        aligned = shifted << bit_cnt;
        drive   = 1'b0;
        if (step == EL_READ) begin
            if (bit_cnt == 4'd8) begin
                drive = (({1'b0, done} + 7'd1) < {1'b0, count});
            end
        end else if (bit_cnt < 4'd8) begin
            drive = ~aligned[7];
        end
        return drive;
    endfunction

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign phase_limit  = (phase_ticks_reg == 16'd0) ? 16'd1 : phase_ticks_reg;
    assign phase_inc    = phase_cnt_reg + 16'd1;
    assign stretch_inc  = stretch_cnt_reg + 16'd1;
    assign delay_over   = (phase_inc >= phase_limit);
    assign stretch_over = (stretch_inc >= stretch_limit_reg);
    assign recover_inc  = recover_reg + 4'd1;

    always_comb begin
        step_next          = step_reg;
        phase_next         = phase_reg;
        phase_cnt_next     = phase_cnt_reg;
        stretch_cnt_next   = stretch_cnt_reg;
        bit_cnt_next       = bit_cnt_reg;
        bytes_done_next    = bytes_done_reg;
        shift_next         = shift_reg;
        command_next       = command_reg;
        held_register_next = held_register_reg;
        held_value_next    = held_value_reg;
        held_count_next    = held_count_reg;
        sda_next           = sda_reg;
        scl_next           = scl_reg;
        recover_next       = recover_reg;
        nack_next          = nack_reg;
        pending_next       = pending_reg;
        result             = '0;

        if (step_reg == EL_IDLE) begin
            if (s_data.operation inside {[OP_WRITE:OP_RECOVER]}) begin
                command_next       = s_data.operation;
                held_register_next = s_data.reg_addr;
                held_value_next    = s_data.write_value;
                held_count_next    = (s_data.read_count == 6'd0 ||
                                      s_data.read_count > BURST_MAX) ?
                                     6'd1 : s_data.read_count;
                bytes_done_next    = 6'd0;
                nack_next          = 1'b0;
                pending_next       = ST_OK;
                phase_cnt_next     = 16'd0;
                stretch_cnt_next   = 16'd0;
                sda_next           = 1'b0;
                scl_next           = 1'b0;
                if (s_data.operation == OP_RECOVER) begin
                    step_next    = EL_CLOCKS;
                    recover_next = 4'd0;
                    phase_next   = PH_CLK_RISE;
                end else begin
                    step_next  = EL_START;
                    phase_next = PH_START_RISE;
                end
            end
        end else begin
            result.command_ignored = (s_data.operation inside {[OP_WRITE:OP_RECOVER]});
            case (phase_reg)
                PH_START_RISE, PH_START_SDA, PH_STOP_SDA, PH_STOP_RISE,
                PH_CLK_RISE, PH_CLK_HIGH: begin
                    phase_cnt_next = phase_inc;
                    if (delay_over) begin
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                        case (phase_reg)
                            PH_START_RISE: begin
                                phase_next = PH_START_WAIT;
                                sda_next   = 1'b0;
                                scl_next   = 1'b0;
                            end
                            PH_START_SDA: begin
                                phase_next = PH_START_SCL;
                                sda_next   = 1'b1;
                                scl_next   = 1'b1;
                            end
                            PH_STOP_SDA: begin
                                phase_next = PH_STOP_RISE;
                                sda_next   = 1'b1;
                                scl_next   = 1'b0;
                            end
                            PH_STOP_RISE: begin
                                phase_next = PH_STOP_WAIT;
                                sda_next   = 1'b1;
                                scl_next   = 1'b0;
                            end
                            PH_CLK_RISE: begin
                                phase_next = PH_CLK_HIGH;
                                sda_next   = 1'b0;
                                scl_next   = 1'b0;
                            end
                            default: begin
                                phase_next = PH_CLK_LOW;
                                sda_next   = 1'b0;
                                scl_next   = 1'b1;
                            end
                        endcase
                    end
                end
                PH_START_WAIT: begin
                    if (s_data.scl_sample) begin
                        phase_next       = PH_START_SDA;
                        sda_next         = 1'b1;
                        scl_next         = 1'b0;
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                    end else begin
                        stretch_cnt_next = stretch_inc;
                        if (stretch_over) begin
                            phase_cnt_next   = 16'd0;
                            stretch_cnt_next = 16'd0;
                            if (step_reg == EL_START) begin
                                // A timeout before the first start leaves the bus alone.
                                step_next       = EL_IDLE;
                                command_next    = OP_TICK;
                                phase_next      = PH_NONE;
                                sda_next        = 1'b0;
                                scl_next        = 1'b0;
                                result.done_res = 1'b1;
                                result.status   = ST_TIMEOUT;
                            end else begin
                                pending_next = ST_TIMEOUT;
                                step_next    = EL_STOP;
                                phase_next   = PH_STOP_SDA;
                                sda_next     = 1'b1;
                            end
                        end
                    end
                end
                PH_START_SCL: begin
                    phase_cnt_next = phase_inc;
                    if (delay_over) begin
                        step_next        = (step_reg == EL_START) ? EL_ADDR_W : EL_ADDR_R;
                        shift_next       = {dev_addr_reg, step_reg != EL_START};
                        bit_cnt_next     = 4'd0;
                        phase_next       = PH_BIT_RISE;
                        sda_next         = ~dev_addr_reg[6];
                        scl_next         = 1'b0;
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                    end
                end
                PH_BIT_RISE: begin
                    phase_cnt_next = phase_inc;
                    if (delay_over) begin
                        // The phase count is left running here; only the stretch count restarts.
                        phase_next       = PH_BIT_WAIT;
                        stretch_cnt_next = 16'd0;
                    end
                end
                PH_BIT_WAIT: begin
                    if (s_data.scl_sample) begin
                        phase_next       = PH_BIT_HIGH;
                        scl_next         = 1'b0;
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                    end else begin
                        stretch_cnt_next = stretch_inc;
                        if (stretch_over) begin
                            pending_next     = ST_TIMEOUT;
                            step_next        = EL_STOP;
                            phase_next       = PH_STOP_SDA;
                            sda_next         = 1'b1;
                            phase_cnt_next   = 16'd0;
                            stretch_cnt_next = 16'd0;
                        end
                    end
                end
                PH_BIT_HIGH: begin
                    phase_cnt_next = phase_inc;
                    if (delay_over) begin
                        if (step_reg == EL_READ) begin
                            if (bit_cnt_reg < 4'd8) begin
                                shift_next = {shift_reg[6:0], s_data.sda_sample};
                            end
                        end else if (bit_cnt_reg == 4'd8) begin
                            nack_next = s_data.sda_sample;
                        end
                        phase_next       = PH_BIT_LOW;
                        scl_next         = 1'b1;
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                    end
                end
                PH_BIT_LOW: begin
                    phase_cnt_next = phase_inc;
                    if (delay_over) begin
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                        if (bit_cnt_reg < 4'd8) begin
                            bit_cnt_next = bit_cnt_reg + 4'd1;
                            phase_next   = PH_BIT_RISE;
                            sda_next     = bit_sda(step_reg, bit_cnt_next, shift_reg,
                                                   bytes_done_reg, held_count_reg);
                            scl_next     = 1'b0;
                        end else begin
                            // End of byte: choose the next byte, a restart or a stop.
                            // A stop keeps SCL where it is and raises SDA drive.
                            case (step_reg)
                                EL_ADDR_W, EL_REG, EL_ADDR_R: begin
                                    if (nack_reg) begin
                                        pending_next = ST_NACK;
                                        step_next    = EL_STOP;
                                        phase_next   = PH_STOP_SDA;
                                        sda_next     = 1'b1;
                                    end else if (step_reg == EL_ADDR_W &&
                                                 command_reg == OP_PROBE) begin
                                        pending_next = ST_OK;
                                        step_next    = EL_STOP;
                                        phase_next   = PH_STOP_SDA;
                                        sda_next     = 1'b1;
                                    end else if (step_reg == EL_ADDR_W) begin
                                        step_next    = EL_REG;
                                        shift_next   = held_register_reg;
                                        bit_cnt_next = 4'd0;
                                        phase_next   = PH_BIT_RISE;
                                        sda_next     = ~held_register_reg[7];
                                        scl_next     = 1'b0;
                                    end else if (step_reg == EL_REG &&
                                                 command_reg == OP_WRITE) begin
                                        step_next    = EL_VAL;
                                        shift_next   = held_value_reg;
                                        bit_cnt_next = 4'd0;
                                        phase_next   = PH_BIT_RISE;
                                        sda_next     = ~held_value_reg[7];
                                        scl_next     = 1'b0;
                                    end else if (step_reg == EL_REG) begin
                                        step_next  = EL_RESTART;
                                        phase_next = PH_START_RISE;
                                        sda_next   = 1'b0;
                                        scl_next   = 1'b0;
                                    end else begin
                                        bytes_done_next = 6'd0;
                                        step_next       = EL_READ;
                                        shift_next      = 8'd0;
                                        bit_cnt_next    = 4'd0;
                                        phase_next      = PH_BIT_RISE;
                                        sda_next        = 1'b0;
                                        scl_next        = 1'b0;
                                    end
                                end
                                EL_VAL: begin
                                    pending_next = nack_reg ? ST_NACK : ST_OK;
                                    step_next    = EL_STOP;
                                    phase_next   = PH_STOP_SDA;
                                    sda_next     = 1'b1;
                                end
                                EL_READ: begin
                                    bytes_done_next   = bytes_done_reg + 6'd1;
                                    result.byte_valid = 1'b1;
                                    result.byte_value = shift_reg;
                                    result.byte_last  = (bytes_done_next >= held_count_reg);
                                    if (result.byte_last) begin
                                        pending_next = ST_OK;
                                        step_next    = EL_STOP;
                                        phase_next   = PH_STOP_SDA;
                                        sda_next     = 1'b1;
                                    end else begin
                                        shift_next   = 8'd0;
                                        bit_cnt_next = 4'd0;
                                        phase_next   = PH_BIT_RISE;
                                        sda_next     = 1'b0;
                                        scl_next     = 1'b0;
                                    end
                                end
                                default: begin
                                    pending_next = ST_OK;
                                    step_next    = EL_STOP;
                                    phase_next   = PH_STOP_SDA;
                                    sda_next     = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                PH_STOP_WAIT: begin
                    // A stretch timeout here does not abort; the stop goes on.
                    if (!s_data.scl_sample) begin
                        stretch_cnt_next = stretch_inc;
                    end
                    if (s_data.scl_sample || stretch_over) begin
                        phase_next       = PH_STOP_END;
                        sda_next         = 1'b0;
                        scl_next         = 1'b0;
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                    end
                end
                PH_STOP_END: begin
                    phase_cnt_next = phase_inc;
                    if (delay_over) begin
                        step_next        = EL_IDLE;
                        command_next     = OP_TICK;
                        phase_next       = PH_NONE;
                        sda_next         = 1'b0;
                        scl_next         = 1'b0;
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                        result.done_res  = 1'b1;
                        result.status    = pending_reg;
                    end
                end
                PH_CLK_LOW: begin
                    phase_cnt_next = phase_inc;
                    if (delay_over) begin
                        recover_next     = recover_inc;
                        phase_cnt_next   = 16'd0;
                        stretch_cnt_next = 16'd0;
                        if (recover_inc >= RECOVER_COUNT) begin
                            pending_next = ST_OK;
                            step_next    = EL_STOP;
                            phase_next   = PH_STOP_SDA;
                            sda_next     = 1'b1;
                        end else begin
                            phase_next = PH_CLK_RISE;
                            sda_next   = 1'b0;
                            scl_next   = 1'b0;
                        end
                    end
                end
                default: begin
                    step_next        = EL_IDLE;
                    command_next     = OP_TICK;
                    phase_next       = PH_NONE;
                    sda_next         = 1'b0;
                    scl_next         = 1'b0;
                    phase_cnt_next   = 16'd0;
                    stretch_cnt_next = 16'd0;
                    result.done_res  = 1'b1;
                    result.status    = ST_OK;
                end
            endcase
        end

        result.sda_pull_low = sda_next;
        result.scl_pull_low = scl_next;
        result.busy_res     = (step_next != EL_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg      <= ADDR_RESET;
            phase_ticks_reg   <= PHASE_RESET;
            stretch_limit_reg <= STRETCH_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_DEVICE_ADDRESS: dev_addr_reg      <= cfg_wr_data[6:0];
                CFG_PHASE_TICKS:    phase_ticks_reg   <= cfg_wr_data;
                CFG_STRETCH_LIMIT:  stretch_limit_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg          <= EL_IDLE;
            phase_reg         <= PH_NONE;
            phase_cnt_reg     <= 16'd0;
            stretch_cnt_reg   <= 16'd0;
            bit_cnt_reg       <= 4'd0;
            bytes_done_reg    <= 6'd0;
            shift_reg         <= 8'd0;
            command_reg       <= OP_TICK;
            held_register_reg <= 8'd0;
            held_value_reg    <= 8'd0;
            held_count_reg    <= 6'd1;
            sda_reg           <= 1'b0;
            scl_reg           <= 1'b0;
            recover_reg       <= 4'd0;
            nack_reg          <= 1'b0;
            pending_reg       <= ST_OK;
        end else if (accept) begin
            step_reg          <= step_next;
            phase_reg         <= phase_next;
            phase_cnt_reg     <= phase_cnt_next;
            stretch_cnt_reg   <= stretch_cnt_next;
            bit_cnt_reg       <= bit_cnt_next;
            bytes_done_reg    <= bytes_done_next;
            shift_reg         <= shift_next;
            command_reg       <= command_next;
            held_register_reg <= held_register_next;
            held_value_reg    <= held_value_next;
            held_count_reg    <= held_count_next;
            sda_reg           <= sda_next;
            scl_reg           <= scl_next;
            recover_reg       <= recover_next;
            nack_reg          <= nack_next;
            pending_reg       <= pending_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    `I2CRM_ASSERT_NOW(a_idle_released, step_reg == EL_IDLE, phase_reg == PH_NONE && !sda_reg && !scl_reg, "idle with a line driven or a phase open")
    `I2CRM_ASSERT_NEXT(a_result_follows, accept, m_valid, "input transfer without a result")
    `I2CRM_ASSERT_NOW(a_done_not_busy, m_valid && m_data.done_res, !m_data.busy_res, "done reported while still busy")
    `I2CRM_ASSERT_NOW(a_byte_busy, m_valid && m_data.byte_valid, m_data.busy_res && !m_data.done_res, "read byte outside a running burst")

endmodule

`default_nettype wire

// File: test/i2c_register_master_tb.sv
`timescale 1ns / 1ps

module i2c_register_master_tb;
    import i2crm_pkg::*;

    localparam int OP_CODE_MAX = 7;
    localparam int DRAIN_LIMIT = 100000;
    localparam int PRINT_LIMIT = 40;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_index = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    i2c_register_master u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Bus sequencer copy, advanced once per accepted input transfer.
    logic [6:0]  cfg_addr    = ADDR_RESET;
    logic [15:0] cfg_phase   = PHASE_RESET;
    logic [15:0] cfg_stretch = STRETCH_RESET;

    logic [3:0]  cur_step    = EL_IDLE;
    logic [3:0]  cur_phase   = PH_NONE;
    logic [15:0] delay_cnt   = '0;
    logic [15:0] wait_cnt    = '0;
    logic [3:0]  bit_idx     = '0;
    logic [5:0]  bytes_read  = '0;
    logic [7:0]  shreg       = '0;
    logic [2:0]  cmd         = OP_TICK;
    logic [7:0]  reg_hold    = '0;
    logic [7:0]  val_hold    = '0;
    logic [5:0]  count_hold  = 6'd1;
    logic        drive_sda   = 1'b0;
    logic        drive_scl   = 1'b0;
    logic [3:0]  clk_pulses  = '0;
    logic        saw_nack    = 1'b0;
    logic [1:0]  stop_status = ST_OK;
    out_item_t   tick_res;

    out_item_t   expected_ticks[$];
    out_item_t   want_res;

    int mismatches    = 0;
    int ticks_checked = 0;
    int items_sent    = 0;
    int burst_left    = 0;
    int cmds_ok       = 0;
    int cmds_nack     = 0;
    int cmds_timeout  = 0;
    int bytes_seen    = 0;
    int drops_seen    = 0;

    logic [7:0]  ready_age  = '0;
    logic [1:0]  ready_mode = '0;

    function automatic void go_phase(input logic [3:0] ph, input logic sda, input logic scl);
        cur_phase = ph;
        drive_sda = sda;
        drive_scl = scl;
        delay_cnt = '0;
        wait_cnt  = '0;
    endfunction

    function automatic bit delay_done();
        delay_cnt = delay_cnt + 16'd1;
        return delay_cnt >= ((cfg_phase == 16'd0) ? 16'd1 : cfg_phase);
    endfunction

    function automatic bit stretch_done();
        wait_cnt = wait_cnt + 16'd1;
        return wait_cnt >= cfg_stretch;
    endfunction

    // Writes put the data bit on SDA (pull low for a zero) and release SDA for
    // the ACK slot; reads release SDA for data and pull it low to acknowledge.
    function automatic void launch_bit();
        logic sda;
        sda = 1'b0;
        if (cur_step == EL_READ) begin
            if (bit_idx == 4'd8) sda = (int'(bytes_read) + 1 < int'(count_hold));
        end else if (bit_idx < 4'd8) begin
            sda = ~shreg[3'd7 - bit_idx[2:0]];
        end
        go_phase(PH_BIT_RISE, sda, 1'b0);
    endfunction

    function automatic void launch_byte(input logic [3:0] step, input logic [7:0] value);
        cur_step = step;
        shreg    = value;
        bit_idx  = '0;
        launch_bit();
    endfunction

    function automatic void launch_stop(input logic [1:0] st);
        stop_status = st;
        cur_step    = EL_STOP;
        go_phase(PH_STOP_SDA, 1'b1, drive_scl);
    endfunction

    function automatic void end_command(input logic [1:0] st);
        cur_step = EL_IDLE;
        cmd      = OP_TICK;
        go_phase(PH_NONE, 1'b0, 1'b0);
        tick_res.done_res = 1'b1;
        tick_res.status   = st;
    endfunction

    function automatic out_item_t bus_tick(input in_item_t it);
        logic       is_cmd;
        logic [7:0] addr_byte;
        is_cmd    = (it.operation >= OP_WRITE) && (it.operation <= OP_RECOVER);
        addr_byte = {cfg_addr, 1'b0};
        tick_res  = '0;
        if (cur_step == EL_IDLE) begin
            if (is_cmd) begin
                cmd        = it.operation;
                reg_hold   = it.reg_addr;
                val_hold   = it.write_value;
                count_hold = (it.read_count == 6'd0 || it.read_count > MAX_BURST_DEFAULT)
                             ? 6'd1 : it.read_count;
                bytes_read  = '0;
                saw_nack    = 1'b0;
                stop_status = ST_OK;
                if (it.operation == OP_RECOVER) begin
                    cur_step   = EL_CLOCKS;
                    clk_pulses = '0;
                    go_phase(PH_CLK_RISE, 1'b0, 1'b0);
                end else begin
                    cur_step = EL_START;
                    go_phase(PH_START_RISE, 1'b0, 1'b0);
                end
            end
        end else begin
            tick_res.command_ignored = is_cmd;
            case (cur_phase)
                PH_START_RISE: if (delay_done()) go_phase(PH_START_WAIT, 1'b0, 1'b0);
                PH_START_WAIT: begin
                    if (it.scl_sample) begin
                        go_phase(PH_START_SDA, 1'b1, 1'b0);
                    end else if (stretch_done()) begin
                        // Only the first START gives up without a STOP.
                        if (cur_step == EL_START) end_command(ST_TIMEOUT);
                        else launch_stop(ST_TIMEOUT);
                    end
                end
                PH_START_SDA: if (delay_done()) go_phase(PH_START_SCL, 1'b1, 1'b1);
                PH_START_SCL: begin
                    if (delay_done()) begin
                        if (cur_step == EL_START) launch_byte(EL_ADDR_W, addr_byte);
                        else launch_byte(EL_ADDR_R, addr_byte | 8'd1);
                    end
                end
                PH_BIT_RISE: begin
                    // The delay count is left running; the wait phase does not use it.
                    if (delay_done()) begin
                        cur_phase = PH_BIT_WAIT;
                        wait_cnt  = '0;
                    end
                end
                PH_BIT_WAIT: begin
                    if (it.scl_sample) go_phase(PH_BIT_HIGH, drive_sda, 1'b0);
                    else if (stretch_done()) launch_stop(ST_TIMEOUT);
                end
                PH_BIT_HIGH: begin
                    if (delay_done()) begin
                        if (cur_step == EL_READ) begin
                            if (bit_idx < 4'd8) shreg = {shreg[6:0], it.sda_sample};
                        end else if (bit_idx == 4'd8) begin
                            saw_nack = it.sda_sample;
                        end
                        go_phase(PH_BIT_LOW, drive_sda, 1'b1);
                    end
                end
                PH_BIT_LOW: begin
                    if (delay_done()) begin
                        if (bit_idx < 4'd8) begin
                            bit_idx = bit_idx + 4'd1;
                            launch_bit();
                        end else begin
                            case (cur_step)
                                EL_ADDR_W: begin
                                    if (saw_nack) launch_stop(ST_NACK);
                                    else if (cmd == OP_PROBE) launch_stop(ST_OK);
                                    else launch_byte(EL_REG, reg_hold);
                                end
                                EL_REG: begin
                                    if (saw_nack) begin
                                        launch_stop(ST_NACK);
                                    end else if (cmd == OP_WRITE) begin
                                        launch_byte(EL_VAL, val_hold);
                                    end else begin
                                        cur_step = EL_RESTART;
                                        go_phase(PH_START_RISE, 1'b0, 1'b0);
                                    end
                                end
                                EL_VAL: launch_stop(saw_nack ? ST_NACK : ST_OK);
                                EL_ADDR_R: begin
                                    if (saw_nack) begin
                                        launch_stop(ST_NACK);
                                    end else begin
                                        bytes_read = '0;
                                        launch_byte(EL_READ, 8'd0);
                                    end
                                end
                                EL_READ: begin
                                    tick_res.byte_valid = 1'b1;
                                    tick_res.byte_value = shreg;
                                    bytes_read = bytes_read + 6'd1;
                                    tick_res.byte_last = (bytes_read >= count_hold);
                                    if (tick_res.byte_last) launch_stop(ST_OK);
                                    else launch_byte(EL_READ, 8'd0);
                                end
                                default: launch_stop(ST_OK);
                            endcase
                        end
                    end
                end
                PH_STOP_SDA:  if (delay_done()) go_phase(PH_STOP_RISE, 1'b1, 1'b0);
                PH_STOP_RISE: if (delay_done()) go_phase(PH_STOP_WAIT, 1'b1, 1'b0);
                PH_STOP_WAIT: begin
                    // A stretch timeout here is not an error; the STOP just goes on.
                    if (it.scl_sample) go_phase(PH_STOP_END, 1'b0, 1'b0);
                    else if (stretch_done()) go_phase(PH_STOP_END, 1'b0, 1'b0);
                end
                PH_STOP_END: if (delay_done()) end_command(stop_status);
                PH_CLK_RISE: if (delay_done()) go_phase(PH_CLK_HIGH, 1'b0, 1'b0);
                PH_CLK_HIGH: if (delay_done()) go_phase(PH_CLK_LOW, 1'b0, 1'b1);
                PH_CLK_LOW: begin
                    if (delay_done()) begin
                        clk_pulses = clk_pulses + 4'd1;
                        if (clk_pulses >= RECOVER_COUNT) launch_stop(ST_OK);
                        else go_phase(PH_CLK_RISE, 1'b0, 1'b0);
                    end
                end
                default: end_command(ST_OK);
            endcase
        end
        tick_res.sda_pull_low = drive_sda;
        tick_res.scl_pull_low = drive_scl;
        tick_res.busy_res     = (cur_step != EL_IDLE);
        return tick_res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("ERROR result %0d: %s got %0h expected %0h", ticks_checked, what, got, want);
    endtask

    task automatic compare_field(input string name, input logic [7:0] got,
                                 input logic [7:0] want);
        if (got !== want) report_mismatch(name, got, want);
    endtask

    // Receiver: changes its stall pattern each time the 8-bit age counter wraps.
    always @(posedge aclk) begin
        ready_age <= ready_age + 8'd1;
        if (ready_age == 8'd0) ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            2'd0:    m_ready <= 1'b1;
            2'd1:    m_ready <= ($urandom_range(0, 1) == 1);
            2'd2:    m_ready <= (ready_age[1:0] != 2'b11);
            default: m_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            ticks_checked++;
            if (expected_ticks.size() == 0) begin
                report_mismatch("result with nothing expected", m_data, 0);
            end else begin
                want_res = expected_ticks.pop_front();
                compare_field("sda_pull_low", m_data.sda_pull_low, want_res.sda_pull_low);
                compare_field("scl_pull_low", m_data.scl_pull_low, want_res.scl_pull_low);
                compare_field("busy_res", m_data.busy_res, want_res.busy_res);
                compare_field("byte_valid", m_data.byte_valid, want_res.byte_valid);
                compare_field("byte_value", m_data.byte_value, want_res.byte_value);
                compare_field("byte_last", m_data.byte_last, want_res.byte_last);
                compare_field("done_res", m_data.done_res, want_res.done_res);
                compare_field("status", m_data.status, want_res.status);
                compare_field("command_ignored", m_data.command_ignored,
                              want_res.command_ignored);
                if (want_res.byte_valid) bytes_seen++;
                if (want_res.command_ignored) drops_seen++;
                if (want_res.done_res) begin
                    case (want_res.status)
                        ST_OK:   cmds_ok++;
                        ST_NACK: cmds_nack++;
                        default: cmds_timeout++;
                    endcase
                end
            end
        end
    end

    // One tick per transfer; the sender runs in bursts with idle gaps between them.
    task automatic send_tick(input in_item_t it);
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        expected_ticks.push_back(bus_tick(it));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(0, 15);
        end
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_ticks.size() != 0) begin
            report_mismatch("results never arrived", expected_ticks.size(), 0);
            expected_ticks.delete();
        end
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(posedge aclk);
        case (idx)
            CFG_DEVICE_ADDRESS: cfg_addr    = data[6:0];
            CFG_PHASE_TICKS:    cfg_phase   = data;
            CFG_STRETCH_LIMIT:  cfg_stretch = data;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [6:0] addr, input logic [15:0] phase,
                             input logic [15:0] limit);
        logic [15:0] addr_word;
        wait_drained();
        // Upper bits of the address word are don't-care and get random values.
        addr_word      = $urandom;
        addr_word[6:0] = addr;
        write_reg(CFG_DEVICE_ADDRESS, addr_word);
        write_reg(CFG_PHASE_TICKS, phase);
        write_reg(CFG_STRETCH_LIMIT, limit);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Issues one command and then clocks the bus until the sequencer is idle.
    // The target side follows the master's drives: SCL reads high unless pulled
    // low, held low at random (hold_pct) or for the whole of stall_step; ACK slots
    // read high with nack_pct percent; read data bits are random.
    task automatic run_command(input logic [2:0] op, input logic [7:0] reg_a,
                               input logic [7:0] val, input logic [5:0] cnt,
                               input int nack_pct, input int hold_pct,
                               input logic [3:0] stall_step, input int noise_pct);
        in_item_t it;
        it.operation   = op;
        it.reg_addr    = reg_a;
        it.write_value = val;
        it.read_count  = cnt;
        it.sda_sample  = $urandom;
        it.scl_sample  = $urandom;
        send_tick(it);
        while (cur_step != EL_IDLE) begin
            if ($urandom_range(0, 99) < noise_pct) it.operation = $urandom_range(1, OP_CODE_MAX);
            else it.operation = OP_TICK;
            it.reg_addr    = $urandom;
            it.write_value = $urandom;
            it.read_count  = $urandom;
            it.scl_sample  = !drive_scl && cur_step != stall_step
                             && $urandom_range(0, 99) >= hold_pct;
            if (drive_sda) it.sda_sample = 1'b0;
            else if (cur_step != EL_READ && bit_idx == 4'd8)
                it.sda_sample = ($urandom_range(0, 99) < nack_pct);
            else it.sda_sample = $urandom;
            send_tick(it);
        end
    endtask

    task automatic test_reset_defaults();
        run_command(OP_PROBE, 8'h00, 8'h00, 6'd1, 0, 0, EL_IDLE, 0);
        run_command(OP_PROBE, 8'hFF, 8'hFF, 6'd1, 100, 0, EL_IDLE, 0);
    endtask

    task automatic test_register_write();
        configure(7'h55, 16'd1, STRETCH_RESET);
        run_command(OP_WRITE, 8'h00, 8'hFF, 6'd1, 0, 0, EL_IDLE, 0);
        run_command(OP_WRITE, 8'hFF, 8'h00, 6'd1, 0, 0, EL_IDLE, 0);
        run_command(OP_WRITE, 8'h3C, 8'hC3, 6'd1, 100, 0, EL_IDLE, 0);
        run_command(OP_WRITE, $urandom, $urandom, 6'd1, 50, 10, EL_IDLE, 0);
    endtask

    task automatic test_burst_read();
        configure(7'h2A, PHASE_RESET, STRETCH_RESET);
        run_command(OP_READ, 8'h10, 8'h00, 6'd1, 0, 0, EL_IDLE, 0);
        run_command(OP_READ, 8'h20, 8'h00, 6'd32, 0, 5, EL_IDLE, 0);
        // A count of zero or past the burst limit reads a single byte.
        run_command(OP_READ, 8'h30, 8'h00, 6'd0, 0, 0, EL_IDLE, 0);
        run_command(OP_READ, 8'h40, 8'h00, 6'd63, 0, 0, EL_IDLE, 0);
        run_command(OP_READ, 8'h50, 8'h00, 6'd33, 0, 0, EL_IDLE, 0);
    endtask

    task automatic test_bus_recovery();
        configure(7'h0E, 16'd3, STRETCH_RESET);
        run_command(OP_RECOVER, $urandom, $urandom, $urandom, 0, 0, EL_IDLE, 0);
    endtask

    task automatic test_ignored_commands();
        configure(7'h0E, 16'd1, STRETCH_RESET);
        run_command(OP_WRITE, 8'hA5, 8'h5A, 6'd1, 0, 0, EL_IDLE, 40);
        for (int op = OP_RECOVER + 1; op <= OP_CODE_MAX; op++)
            run_command(op, $urandom, $urandom, $urandom, 0, 0, EL_IDLE, 0);
        run_command(OP_TICK, $urandom, $urandom, $urandom, 0, 0, EL_IDLE, 0);
    endtask

    task automatic test_timeouts();
        configure(7'h33, 16'd1, 16'd1);
        run_command(OP_READ, 8'h01, 8'h00, 6'd2, 0, 0, EL_START, 0);
        run_command(OP_WRITE, 8'h02, 8'h99, 6'd1, 0, 0, EL_REG, 0);
        run_command(OP_READ, 8'h03, 8'h00, 6'd2, 0, 0, EL_RESTART, 0);
        run_command(OP_PROBE, 8'h04, 8'h00, 6'd1, 0, 0, EL_STOP, 0);
        // With a zero limit any low SCL sample in a start or bit wait phase ends the command,
        // usually partway through the burst.
        configure(7'h33, 16'd1, 16'd0);
        run_command(OP_READ, 8'h05, 8'h00, 6'd8, 0, 3, EL_IDLE, 0);
        run_command(OP_WRITE, 8'h06, 8'h66, 6'd1, 0, 20, EL_IDLE, 0);
    endtask

    task automatic test_config_extremes();
        configure(7'h00, 16'd0, STRETCH_RESET);
        run_command(OP_PROBE, 8'h00, 8'h00, 6'd1, 0, 0, EL_IDLE, 0);
        configure(7'h7F, 16'd1, 16'hFFFF);
        run_command(OP_WRITE, 8'h81, 8'h7E, 6'd1, 0, 0, EL_IDLE, 0);
        run_command(OP_PROBE, 8'h00, 8'h00, 6'd1, 0, 0, EL_START, 0);
        configure(7'h7F, 16'hFFFF, 16'd1);
        run_command(OP_READ, 8'h00, 8'h00, 6'd1, 0, 0, EL_START, 0);
    endtask

    task automatic test_random_traffic();
        int          stop_at;
        int          pick;
        int          nack_pct;
        int          hold_pct;
        int          noise_pct;
        logic [2:0]  op;
        logic [5:0]  cnt;
        logic [3:0]  stall;
        logic [15:0] phase;
        logic [15:0] limit;
        stop_at = items_sent + 1650;
        while (items_sent < stop_at) begin
            case ($urandom_range(0, 3))
                0:       phase = 16'd0;
                3:       phase = 16'd2;
                default: phase = 16'd1;
            endcase
            case ($urandom_range(0, 3))
                0:       limit = 16'd0;
                1:       limit = 16'd1;
                2:       limit = $urandom_range(2, 12);
                default: limit = STRETCH_RESET;
            endcase
            configure($urandom, phase, limit);
            repeat ($urandom_range(2, 5)) begin
                pick = $urandom_range(0, 99);
                if (pick < 30) op = OP_WRITE;
                else if (pick < 60) op = OP_READ;
                else if (pick < 75) op = OP_PROBE;
                else if (pick < 85) op = OP_RECOVER;
                else op = $urandom_range(OP_TICK, OP_CODE_MAX);
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 4);
                case ($urandom_range(0, 4))
                    0, 1:    nack_pct = 0;
                    2:       nack_pct = 5;
                    3:       nack_pct = 30;
                    default: nack_pct = 100;
                endcase
                case ($urandom_range(0, 4))
                    3:       hold_pct = 5;
                    4:       hold_pct = 20;
                    default: hold_pct = 0;
                endcase
                if (limit < STRETCH_RESET && $urandom_range(0, 4) == 0)
                    stall = $urandom_range(EL_START, EL_STOP);
                else
                    stall = EL_IDLE;
                if (pick >= 85) begin
                    noise_pct = 50;
                    nack_pct  = 50;
                    hold_pct  = 20;
                end else begin
                    noise_pct = ($urandom_range(0, 3) == 0) ? 5 : 0;
                end
                run_command(op, $urandom, $urandom, cnt, nack_pct, hold_pct, stall, noise_pct);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_register_write();
        test_burst_read();
        test_bus_recovery();
        test_ignored_commands();
        test_timeouts();
        test_config_extremes();
        test_random_traffic();
        wait_drained();
        repeat (5) @(posedge aclk);
        $display("Checked %0d bus ticks over %0d commands: %0d ok, %0d no ack, %0d timeout.",
                 ticks_checked, cmds_ok + cmds_nack + cmds_timeout, cmds_ok, cmds_nack,
                 cmds_timeout);
        $display("Read bytes delivered: %0d; commands dropped while busy: %0d; mismatches: %0d.",
                 bytes_seen, drops_seen, mismatches);
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/i2crm_pkg.sv
src/i2c_register_master.sv
test/i2c_register_master_tb.sv
